>>> rtl/sc1a_pkg.sv
// Package for the set 1 scancode decoder: scancode constants and the
// character ROM lookup. No dependencies.

package sc1a_pkg;

   localparam logic [7:0] PREFIX_BYTE = 8'hE0;
   localparam logic [7:0] LAST_KEY    = 8'h3A;

   localparam logic [6:0] KEY_LCTRL   = 7'h1D;
   localparam logic [6:0] KEY_LSHIFT  = 7'h2A;
   localparam logic [6:0] KEY_RSHIFT  = 7'h36;
   localparam logic [6:0] KEY_ALT     = 7'h38;
   localparam logic [6:0] KEY_CAPS    = 7'h3A;

   localparam int unsigned CHAR_WIDTH = 7;

   // Digit and symbol keys: caps lock has no effect on them.
   function automatic logic shift_only_key(input logic [5:0] code);
      return (code < 6'h0E) || (code == 6'h29) || (code == 6'h1A) ||
             (code == 6'h1B) || (code == 6'h2B) || (code == 6'h27) ||
             (code == 6'h28) || (code == 6'h33) || (code == 6'h34) ||
             (code == 6'h35);
   endfunction

   // Character ROM, {normal, shifted}. Zero marks a modifier or unused key.
   function automatic logic [CHAR_WIDTH-1:0] key_char(input logic [5:0] code,
                                                      input logic       upper);
      logic [2*CHAR_WIDTH-1:0] pair;
      unique case (code)
         6'h01: pair = {7'h1B, 7'h1B};
         6'h02: pair = {7'h31, 7'h21};
         6'h03: pair = {7'h32, 7'h40};
         6'h04: pair = {7'h33, 7'h23};
         6'h05: pair = {7'h34, 7'h24};
         6'h06: pair = {7'h35, 7'h25};
         6'h07: pair = {7'h36, 7'h5E};
         6'h08: pair = {7'h37, 7'h26};
         6'h09: pair = {7'h38, 7'h2A};
         6'h0A: pair = {7'h39, 7'h28};
         6'h0B: pair = {7'h30, 7'h29};
         6'h0C: pair = {7'h2D, 7'h5F};
         6'h0D: pair = {7'h3D, 7'h2B};
         6'h0E: pair = {7'h08, 7'h08};
         6'h0F: pair = {7'h09, 7'h09};
         6'h10: pair = {7'h71, 7'h51};
         6'h11: pair = {7'h77, 7'h57};
         6'h12: pair = {7'h65, 7'h45};
         6'h13: pair = {7'h72, 7'h52};
         6'h14: pair = {7'h74, 7'h54};
         6'h15: pair = {7'h79, 7'h59};
         6'h16: pair = {7'h75, 7'h55};
         6'h17: pair = {7'h69, 7'h49};
         6'h18: pair = {7'h6F, 7'h4F};
         6'h19: pair = {7'h70, 7'h50};
         6'h1A: pair = {7'h5B, 7'h7B};
         6'h1B: pair = {7'h5D, 7'h7D};
         6'h1C: pair = {7'h0D, 7'h0D};
         6'h1E: pair = {7'h61, 7'h41};
         6'h1F: pair = {7'h73, 7'h53};
         6'h20: pair = {7'h64, 7'h44};
         6'h21: pair = {7'h66, 7'h46};
         6'h22: pair = {7'h67, 7'h47};
         6'h23: pair = {7'h68, 7'h48};
         6'h24: pair = {7'h6A, 7'h4A};
         6'h25: pair = {7'h6B, 7'h4B};
         6'h26: pair = {7'h6C, 7'h4C};
         6'h27: pair = {7'h3B, 7'h3A};
         6'h28: pair = {7'h27, 7'h22};
         6'h29: pair = {7'h60, 7'h7E};
         6'h2B: pair = {7'h5C, 7'h7C};
         6'h2C: pair = {7'h7A, 7'h5A};
         6'h2D: pair = {7'h78, 7'h58};
         6'h2E: pair = {7'h63, 7'h43};
         6'h2F: pair = {7'h76, 7'h56};
         6'h30: pair = {7'h62, 7'h42};
         6'h31: pair = {7'h6E, 7'h4E};
         6'h32: pair = {7'h6D, 7'h4D};
         6'h33: pair = {7'h2C, 7'h3C};
         6'h34: pair = {7'h2E, 7'h3E};
         6'h35: pair = {7'h2F, 7'h3F};
         6'h37: pair = {7'h2A, 7'h2A};
         6'h39: pair = {7'h20, 7'h20};
         default: pair = '0;
      endcase
      return upper ? pair[CHAR_WIDTH-1:0] : pair[2*CHAR_WIDTH-1:CHAR_WIDTH];
   endfunction

endpackage

>>> rtl/scancode_set1_to_ascii.sv
// Set 1 scancode to ASCII decoder: modifier/prefix state and a result register.
// Depends on sc1a_pkg (constants, character ROM).
//
//  channel  ports                                            dir   handshake
//  req      req_scan_byte                                    in    req_valid/req_ready
//  rsp      rsp_char_code, rsp_unknown_key, rsp_ctrl_held,   out   rsp_valid/rsp_ready
//           rsp_alt_held
//
// One byte per cycle unless stalled: lookup and flag update sit between
// the request port and one result register. A result appears the cycle
// after its transfer. Prefix, break and modifier bytes give no result.
// req_ready is low only while a result waits and rsp_ready is low.
// Synchronous reset clears the prefix and modifier flags and the result valid.

module scancode_set1_to_ascii (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_scan_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [sc1a_pkg::CHAR_WIDTH-1:0] rsp_char_code,
   output logic       rsp_unknown_key,
   output logic       rsp_ctrl_held,
   output logic       rsp_alt_held
);
   import sc1a_pkg::*;

   logic prefix_ff, prefix_in;
   logic ctrl_ff, ctrl_in;
   logic shift_ff, shift_in;
   logic alt_ff, alt_in;
   logic caps_ff, caps_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAR_WIDTH-1:0] char_ff, char_in;
   logic                  unknown_ff, unknown_in;
   logic                  ctrl_held_ff, alt_held_ff;

   logic                  accept;
   logic                  emit;
   logic                  ext;
   logic [6:0]            low7;
   logic                  known_key;
   logic                  upper;
   logic [CHAR_WIDTH-1:0] ch;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign ext       = prefix_ff;
   assign low7      = req_scan_byte[6:0];

   assign known_key = ext ? (low7 == KEY_ALT || low7 == KEY_LCTRL)
                          : (req_scan_byte != '0 && req_scan_byte <= LAST_KEY);
   // extended codes never count as shift-only keys
   assign upper = (!ext && shift_only_key(req_scan_byte[5:0])) ? shift_ff
                                                              : (shift_ff || caps_ff);
   assign ch    = known_key ? key_char(req_scan_byte[5:0], upper) : '0;

   always_comb begin
      prefix_in  = prefix_ff;
      ctrl_in    = ctrl_ff;
      shift_in   = shift_ff;
      alt_in     = alt_ff;
      caps_in    = caps_ff;
      emit       = 1'b0;
      char_in    = ch;
      unknown_in = 1'b0;
      if (accept) begin
         prefix_in = (req_scan_byte == PREFIX_BYTE);
         if (req_scan_byte == PREFIX_BYTE) begin
            prefix_in = 1'b1;
         end else if (req_scan_byte[7]) begin
            if (low7 == KEY_LCTRL) ctrl_in = 1'b0;
            if (low7 == KEY_ALT)   alt_in  = 1'b0;
            if (!ext && (low7 == KEY_LSHIFT || low7 == KEY_RSHIFT)) shift_in = 1'b0;
         end else if (known_key) begin
            if (ch != '0) begin
               emit = 1'b1;
            end else begin
               if (low7 == KEY_LCTRL)                        ctrl_in  = 1'b1;
               if (low7 == KEY_ALT)                          alt_in   = 1'b1;
               if (low7 == KEY_LSHIFT || low7 == KEY_RSHIFT) shift_in = 1'b1;
               if (low7 == KEY_CAPS)                         caps_in  = !caps_ff;
            end
         end else begin
            emit       = 1'b1;
            char_in    = '0;
            unknown_in = 1'b1;
         end
      end
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = emit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff    <= 1'b0;
         ctrl_ff      <= 1'b0;
         shift_ff     <= 1'b0;
         alt_ff       <= 1'b0;
         caps_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prefix_ff    <= prefix_in;
         ctrl_ff      <= ctrl_in;
         shift_ff     <= shift_in;
         alt_ff       <= alt_in;
         caps_ff      <= caps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         char_ff      <= char_in;
         unknown_ff   <= unknown_in;
         ctrl_held_ff <= ctrl_ff;
         alt_held_ff  <= alt_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_char_code   = char_ff;
   assign rsp_unknown_key = unknown_ff;
   assign rsp_ctrl_held   = ctrl_held_ff;
   assign rsp_alt_held    = alt_held_ff;

   // a prefix transfer leaves no result behind and arms the prefix flag
   a_prefix_no_result: assert property (@(posedge clock) disable iff (reset)
      (accept && req_scan_byte == PREFIX_BYTE) |=> (!rsp_valid_ff && prefix_ff))
      else $error("prefix byte produced a result or lost the prefix flag");

   a_unknown_zero_char: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && unknown_ff) |-> (char_ff == '0))
      else $error("unknown key result with nonzero character");

   a_caps_toggle: assert property (@(posedge clock) disable iff (reset)
      (accept && !prefix_ff && req_scan_byte == {1'b0, KEY_CAPS})
      |=> (caps_ff != $past(caps_ff)))
      else $error("caps lock make did not toggle");

   a_prefix_one_shot: assert property (@(posedge clock) disable iff (reset)
      (accept && req_scan_byte != PREFIX_BYTE) |=> !prefix_ff)
      else $error("prefix flag survived a non-prefix byte");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid_ff && !caps_ff && !prefix_ff))
      else $error("state not cleared by reset");

endmodule

>>> verif/tb_scancode_set1_to_ascii.sv
// Self-checking testbench for scancode_set1_to_ascii: a scoreboard class that predicts
// decoded characters and modifier flags from the accepted scancode bytes.
// Depends on sc1a_pkg and the scancode_set1_to_ascii RTL.

module tb_scancode_set1_to_ascii;
   timeunit 1ns;
   timeprecision 1ps;

   import sc1a_pkg::*;

   localparam logic [7:0] BREAK_BIT = 8'h80;
   localparam logic [7:0] KEY_A     = 8'h1E;
   localparam logic [7:0] KEY_ONE   = 8'h02;
   localparam logic [7:0] KEY_Q     = 8'h10;
   localparam logic [7:0] KEY_SLASH = 8'h35;
   localparam int         PHASE_BYTES = 500;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] char_code;
      logic                  unknown_key;
      logic                  ctrl_held;
      logic                  alt_held;
   } key_result_type;

   // character table, indexed by make code 0x00..0x3A; zero marks a modifier or unused code
   localparam logic [6:0] PLAIN_CHARS [0:58] = '{
      7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
      7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
      7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0D, 7'h00,
      7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
      7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
      7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00};
   localparam logic [6:0] SHIFTED_CHARS [0:58] = '{
      7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
      7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
      7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0D, 7'h00,
      7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
      7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
      7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00};

   class key_scoreboard;
      key_result_type expected_q[$];
      logic prefix_seen, ctrl_on, shift_on, alt_on, caps_on;
      int   errors, accepted, checked, unknown_count;

      function new();
         prefix_seen = 0;
         ctrl_on = 0;
         shift_on = 0;
         alt_on = 0;
         caps_on = 0;
         errors = 0;
         accepted = 0;
         checked = 0;
         unknown_count = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      task report(string msg);
         $display("%0t ns  MISMATCH: %s", $time, msg);
         errors++;
      endtask

      // digits and symbols: caps lock leaves them alone
      function logic symbol_key(logic [7:0] code);
         if (code < 8'h0E) return 1'b1;
         case (code)
            8'h1A, 8'h1B, 8'h27, 8'h28, 8'h29, 8'h2B, 8'h33, 8'h34, 8'h35: return 1'b1;
            default: return 1'b0;
         endcase
      endfunction

      function void push_result(logic [6:0] ch, logic unknown);
         key_result_type r;
         r.char_code   = ch;
         r.unknown_key = unknown;
         r.ctrl_held   = ctrl_on;
         r.alt_held    = alt_on;
         expected_q.push_back(r);
      endfunction

      function void note_byte(logic [7:0] scan);
         logic       extended;
         logic       upper;
         logic [6:0] ch;
         accepted++;
         if (scan == PREFIX_BYTE) begin
            prefix_seen = 1'b1;
            return;
         end
         extended = prefix_seen;
         prefix_seen = 1'b0;
         if (scan[7]) begin
            // release: only ctrl, shift and alt care; extended shift is not a shift
            if (scan[6:0] == KEY_LCTRL)
               ctrl_on = 1'b0;
            else if (!extended && (scan[6:0] == KEY_LSHIFT || scan[6:0] == KEY_RSHIFT))
               shift_on = 1'b0;
            else if (scan[6:0] == KEY_ALT)
               alt_on = 1'b0;
            return;
         end
         if (extended) begin
            if (scan[6:0] == KEY_ALT)
               alt_on = 1'b1;
            else if (scan[6:0] == KEY_LCTRL)
               ctrl_on = 1'b1;
            else
               push_result('0, 1'b1);
            return;
         end
         if (scan == 8'h00 || scan > LAST_KEY) begin
            push_result('0, 1'b1);
            return;
         end
         upper = symbol_key(scan) ? shift_on : (shift_on | caps_on);
         ch = upper ? SHIFTED_CHARS[scan] : PLAIN_CHARS[scan];
         if (ch != '0) begin
            push_result(ch, 1'b0);
            return;
         end
         case (scan[6:0])
            KEY_LCTRL:              ctrl_on = 1'b1;
            KEY_LSHIFT, KEY_RSHIFT: shift_on = 1'b1;
            KEY_ALT:                alt_on = 1'b1;
            KEY_CAPS:               caps_on = ~caps_on;
            default: ;
         endcase
      endfunction

      task check_result(key_result_type got);
         key_result_type want;
         checked++;
         if (got.unknown_key) unknown_count++;
         if (expected_q.size() == 0) begin
            report($sformatf("result with nothing expected: char %h unknown %b",
                             got.char_code, got.unknown_key));
            return;
         end
         want = expected_q.pop_front();
         if (got.char_code != want.char_code)
            report($sformatf("char_code %h, expected %h", got.char_code, want.char_code));
         if (got.unknown_key != want.unknown_key)
            report($sformatf("unknown_key %b, expected %b", got.unknown_key,
                             want.unknown_key));
         if (got.ctrl_held != want.ctrl_held)
            report($sformatf("ctrl_held %b, expected %b", got.ctrl_held, want.ctrl_held));
         if (got.alt_held != want.alt_held)
            report($sformatf("alt_held %b, expected %b", got.alt_held, want.alt_held));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [7:0]            req_scan_byte = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [CHAR_WIDTH-1:0] rsp_char_code;
   logic                  rsp_unknown_key;
   logic                  rsp_ctrl_held;
   logic                  rsp_alt_held;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   key_scoreboard sb = new();

   scancode_set1_to_ascii dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_scan_byte   (req_scan_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_char_code   (rsp_char_code),
      .rsp_unknown_key (rsp_unknown_key),
      .rsp_ctrl_held   (rsp_ctrl_held),
      .rsp_alt_held    (rsp_alt_held)
   );

   always #6 clock = ~clock;

   // transfers on both channels, sampled at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_byte(req_scan_byte);
         if (rsp_valid && rsp_ready)
            sb.check_result({rsp_char_code, rsp_unknown_key, rsp_ctrl_held, rsp_alt_held});
      end
   end

   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= rsp_stall_pct);
   end

   // called at a falling edge; returns at the falling edge after the transfer
   task send_byte(logic [7:0] scan);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         req_scan_byte = 8'($urandom);
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_scan_byte = scan;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task send_key_event();
      int         sel;
      logic [7:0] scan;
      logic [6:0] key;
      sel = $urandom_range(99);
      if (sel < 40) begin
         // ordinary key, usually released again
         scan = 8'($urandom_range(1, LAST_KEY));
         send_byte(scan);
         if ($urandom_range(3) != 0) send_byte(scan | BREAK_BIT);
      end else if (sel < 58) begin
         case ($urandom_range(3))
            0: key = KEY_LCTRL;
            1: key = KEY_LSHIFT;
            2: key = KEY_RSHIFT;
            default: key = KEY_ALT;
         endcase
         send_byte({1'($urandom_range(1)), key});
      end else if (sel < 63) begin
         send_byte({1'b0, KEY_CAPS});
      end else if (sel < 75) begin
         case ($urandom_range(3))
            0: key = KEY_ALT;
            1: key = KEY_LCTRL;
            default: key = 7'($urandom);
         endcase
         send_byte(PREFIX_BYTE);
         if ($urandom_range(7) == 0) send_byte(PREFIX_BYTE);
         send_byte({1'($urandom_range(1)), key});
      end else if (sel < 85) begin
         if ($urandom_range(9) == 0)
            send_byte(8'h00);
         else
            send_byte(8'($urandom_range(8'h7F, LAST_KEY + 1)));
      end else begin
         send_byte(8'($urandom));
      end
   endtask

   task wait_drained();
      while (sb.pending() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task run_phase(int idle_pct, int stall_pct);
      int start;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      start = sb.accepted;
      while (sb.accepted - start < PHASE_BYTES) send_key_event();
      req_valid = 1'b0;
      wait_drained();
   endtask

   initial begin
      #10_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      logic [7:0] directed[$];
      int         guard;
      directed = '{8'h00, KEY_A, {1'b0, KEY_CAPS}, KEY_A, KEY_ONE,
                   {1'b0, KEY_LSHIFT}, KEY_A, KEY_ONE, {1'b1, KEY_LSHIFT},
                   {1'b0, KEY_CAPS}, {1'b0, KEY_RSHIFT}, {1'b0, KEY_LCTRL},
                   {1'b0, KEY_ALT}, KEY_Q, {1'b1, KEY_RSHIFT}, {1'b1, KEY_LCTRL},
                   {1'b1, KEY_ALT}, PREFIX_BYTE, PREFIX_BYTE, {1'b0, KEY_ALT},
                   KEY_SLASH, PREFIX_BYTE, {1'b1, KEY_ALT}, PREFIX_BYTE,
                   {1'b0, KEY_LCTRL}, LAST_KEY + 8'h01, PREFIX_BYTE, {1'b1, KEY_LCTRL},
                   PREFIX_BYTE, KEY_SLASH, 8'h7F, 8'hFF};
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) send_byte(directed[i]);
      req_valid = 1'b0;
      wait_drained();

      run_phase(0, 0);
      run_phase(85, 0);
      run_phase(0, 85);
      run_phase(23, 23);

      guard = 0;
      while (sb.pending() != 0 && guard < 10000) begin
         @(negedge clock);
         guard++;
      end
      repeat (4) @(negedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d expected results never arrived", sb.pending()));

      $display("Fed %0d scancode bytes (directed, then four pacing mixes).", sb.accepted);
      $display("Checked %0d results, %0d of them unknown-key.", sb.checked,
               sb.unknown_count);
      if (sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
